/* hdl/wtcm_pkg.sv */
// ----------------------------------------------------------------------------
// wtcm_pkg
// Shared types, constants and helpers for the wall texture column mapper.
// ----------------------------------------------------------------------------
package wtcm_pkg;

	localparam int VIEW_ROWS = 480;
	localparam logic signed [13:0] HALF_SCREEN = 14'(VIEW_ROWS / 2);

	localparam logic [1:0] FACE_NORTH = 2'd0;
	localparam logic [1:0] FACE_SOUTH = 2'd1;
	localparam logic [1:0] FACE_WEST  = 2'd2;
	localparam logic [1:0] FACE_EAST  = 2'd3;

	localparam logic REQ_SETUP = 1'b0;
	localparam logic REQ_TICK  = 1'b1;

	localparam logic MODE_DIV  = 1'b0;
	localparam logic MODE_SQRT = 1'b1;

	localparam int ITER_W = 42;

	typedef struct packed {
		logic               req_type;
		logic               hit_side;
		logic               step_negative;
		logic signed [15:0] dir_x;
		logic signed [15:0] dir_y;
		logic [15:0]        hit_distance;
		logic [15:0]        player_x;
		logic [15:0]        player_y;
		logic [11:0]        wall_line_height;
		logic [10:0]        span_start;
		logic [10:0]        span_end;
		logic [11:0]        screen_column;
	} in_item_t;

	typedef struct packed {
		logic [11:0] pixel_column;
		logic [10:0] pixel_row;
		logic [1:0]  face;
		logic [9:0]  texel_u;
		logic [9:0]  texel_v;
		logic        last_pixel;
	} out_item_t;

	typedef struct packed {
		logic               active;
		logic [10:0]        row;
		logic [10:0]        end_row;
		logic [11:0]        column;
		logic [1:0]         face;
		logic [9:0]         u;
		logic signed [31:0] pos;
		logic [31:0]        step;
	} col_load_t;

	function automatic logic [10:0] eff_size(input logic [10:0] v);
		logic [10:0] r;
		r = v;
		if (v == 11'd0)
			r = 11'd1;
		else if (v > 11'd1024)
			r = 11'd1024;
		return r;
	endfunction

endpackage

/* hdl/wtcm_iter_unit.sv */
// ----------------------------------------------------------------------------
// wtcm_iter_unit
// Shared shift/compare/subtract unit: restoring divide (1 bit per cycle) or
// integer square root (2 radicand bits per cycle). Operand is left-aligned.
// ----------------------------------------------------------------------------
module wtcm_iter_unit import wtcm_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic              mode,
	input  logic [ITER_W-1:0] operand,
	input  logic [17:0]       divisor,
	input  logic [5:0]        steps,
	output logic              done,
	output logic [ITER_W-1:0] result
);

	logic [ITER_W-1:0] opnd_q;
	logic [ITER_W-1:0] res_q;
	logic [20:0]       rem_q;
	logic [17:0]       div_q;
	logic              mode_q;
	logic [5:0]        cnt_q;
	logic              run_q;
	logic              done_q;

	logic [20:0] rem_sh;
	logic [20:0] trial;
	logic        ge;
	logic [20:0] rem_nx;

	always_comb begin
		if (mode_q == MODE_SQRT) begin
			rem_sh = {rem_q[18:0], opnd_q[ITER_W-1 -: 2]};
			trial  = {res_q[18:0], 2'b01};
		end else begin
			rem_sh = {rem_q[19:0], opnd_q[ITER_W-1]};
			trial  = {3'b000, div_q};
		end
		ge     = rem_sh >= trial;
		rem_nx = ge ? rem_sh - trial : rem_sh;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= steps;
			end else if (run_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			opnd_q <= operand;
			res_q  <= '0;
			rem_q  <= '0;
			div_q  <= divisor;
			mode_q <= mode;
		end else if (run_q) begin
			opnd_q <= (mode_q == MODE_SQRT) ? {opnd_q[ITER_W-3:0], 2'b00}
			                                : {opnd_q[ITER_W-2:0], 1'b0};
			rem_q  <= rem_nx;
			res_q  <= {res_q[ITER_W-2:0], ge};
		end
	end

	assign done   = done_q;
	assign result = res_q;

endmodule

/* hdl/wtcm_pixel_gen.sv */
// ----------------------------------------------------------------------------
// wtcm_pixel_gen
// Per-column row walker: one texel coordinate per tick, output register.
// ----------------------------------------------------------------------------
module wtcm_pixel_gen import wtcm_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             load,
	input  col_load_t        load_data,
	input  logic             tick,
	input  logic [3:0][10:0] heights,
	input  logic             out_stall,
	output logic             out_valid,
	output out_item_t        out_data
);

	logic               active_q;
	logic [10:0]        row_q;
	logic [10:0]        end_q;
	logic [11:0]        col_q;
	logic [1:0]         face_q;
	logic [9:0]         u_q;
	logic signed [31:0] pos_q;
	logic [31:0]        step_q;
	logic               ovld_q;
	out_item_t          out_q;

	logic [10:0]        h;
	logic [9:0]         v;
	logic signed [32:0] sum;
	logic signed [31:0] pos_nx;
	logic               last;
	logic               emit;

	always_comb begin
		h = heights[face_q];
		if (pos_q[31])
			v = '0;
		else if (pos_q[31:16] >= {5'b0, h})
			v = 10'(h - 11'd1);
		else
			v = pos_q[25:16];
		sum = {pos_q[31], pos_q} + $signed({1'b0, step_q});
		// clip at the positive limit
		if (sum[32:31] == 2'b01)
			pos_nx = 32'sh7FFF_FFFF;
		else
			pos_nx = sum[31:0];
		last = row_q == end_q;
		emit = tick && active_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			ovld_q   <= 1'b0;
		end else begin
			if (load)
				active_q <= load_data.active;
			else if (emit && last)
				active_q <= 1'b0;
			if (emit)
				ovld_q <= 1'b1;
			else if (!out_stall)
				ovld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			row_q  <= load_data.row;
			end_q  <= load_data.end_row;
			col_q  <= load_data.column;
			face_q <= load_data.face;
			u_q    <= load_data.u;
			pos_q  <= load_data.pos;
			step_q <= load_data.step;
		end else if (emit) begin
			pos_q <= pos_nx;
			if (!last)
				row_q <= row_q + 11'd1;
		end
		if (emit) begin
			out_q.pixel_column <= col_q;
			out_q.pixel_row    <= row_q;
			out_q.face         <= face_q;
			out_q.texel_u      <= u_q;
			out_q.texel_v      <= v;
			out_q.last_pixel   <= last;
		end
	end

	assign out_valid = ovld_q;
	assign out_data  = out_q;

endmodule

/* hdl/wall_texture_column_mapper_unit.sv */
// ----------------------------------------------------------------------------
// wall_texture_column_mapper_unit
// Raycaster wall column setup and per-row texel coordinate generator.
// ----------------------------------------------------------------------------
// Input beats carry either a column setup or a pixel tick; output beats carry
// one texel coordinate per tick of an active column. Ticks while no column is
// active are taken and produce nothing.
// A tick's result sits in the output register the cycle after it is taken;
// ticks stream at one per cycle while in_stall is low.
// A setup keeps in_stall high after it is taken until the sequencer is idle
// again: squares, square root, offset divide, step divide, multiply and load.
// The root and both divides share the one shift/subtract unit.
// When the receiver stalls and a result is held, in_stall is high.
// Reset sets all size registers to 64 and leaves no column active.
// Configuration beats are always taken (cfg_ready is tied high); write them
// only while idle.
// ----------------------------------------------------------------------------
module wall_texture_column_mapper_unit import wtcm_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  in_item_t    in_data,
	output logic        out_valid,
	input  logic        out_stall,
	output out_item_t   out_data,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [10:0] cfg_data
);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_SQ   = 3'd1;
	localparam logic [2:0] S_SQRT = 3'd2;
	localparam logic [2:0] S_DIV1 = 3'd3;
	localparam logic [2:0] S_DIV2 = 3'd4;
	localparam logic [2:0] S_POS  = 3'd5;
	localparam logic [2:0] S_LOAD = 3'd6;

	logic [2:0] state_q;

	logic [7:0][10:0] cfg_q;
	logic [3:0][10:0] heights;

	logic [1:0]  face_q;
	logic [10:0] w_q;
	logic [10:0] h_q;
	logic [11:0] lh_q;
	logic [15:0] mx_q;
	logic [15:0] my_q;
	logic [15:0] mag_q;
	logic [15:0] dist_q;
	logic [15:0] pos_q;
	logic        dneg_q;
	logic        mirror_q;
	logic [10:0] s0_q;
	logic [10:0] s1_q;
	logic [11:0] col_q;
	logic [31:0] dm_q;
	logic        len_zero_q;
	logic [26:0] uprod_q;
	logic [26:0] step_q;
	logic signed [41:0] prod_q;

	logic              accept;
	logic              busy;
	logic              it_start;
	logic              it_mode;
	logic [ITER_W-1:0] it_operand;
	logic [17:0]       it_divisor;
	logic [5:0]        it_steps;
	logic              it_done;
	logic [ITER_W-1:0] it_result;

	logic [1:0]  face_in;
	logic        d_sel_neg;
	logic [15:0] d_sel;
	logic [31:0] sq;
	logic [15:0] off;
	logic [15:0] frac;
	logic [10:0] u_raw;
	logic [10:0] u_fin;
	logic signed [13:0] m;
	logic signed [31:0] pos_sat;
	logic              pix_load;
	col_load_t         load_data;

	assign busy      = state_q != S_IDLE;
	assign in_stall  = busy || (out_valid && out_stall);
	assign accept    = in_valid && !in_stall;
	assign cfg_ready = 1'b1;

	always_comb begin
		for (int i = 0; i < 4; i++)
			heights[i] = eff_size(cfg_q[2*i+1]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 8; i++)
				cfg_q[i] <= 11'd64;
		end else if (cfg_valid && cfg_ready) begin
			cfg_q[cfg_index] <= cfg_data;
		end
	end

	// setup decode
	always_comb begin
		if (in_data.hit_side == 1'b0)
			face_in = in_data.step_negative ? FACE_EAST : FACE_WEST;
		else
			face_in = in_data.step_negative ? FACE_SOUTH : FACE_NORTH;
		d_sel     = in_data.hit_side ? in_data.dir_x : in_data.dir_y;
		d_sel_neg = d_sel[15];
	end

	always_comb begin
		sq    = 32'(mx_q * mx_q) + 32'(my_q * my_q);
		off   = len_zero_q ? 16'd0 : it_result[15:0];
		frac  = {pos_q[7:0], 8'd0} + (dneg_q ? 16'(~off + 16'd1) : off);
		u_raw = uprod_q[26:16];
		u_fin = mirror_q ? (w_q - 11'd1 - u_raw) : u_raw;
		m     = $signed({3'b000, s0_q}) - HALF_SCREEN + $signed({3'b000, lh_q[11:1]});
		if (prod_q > 42'sd2147483647)
			pos_sat = 32'sh7FFF_FFFF;
		else if (prod_q < -42'sd2147483648)
			pos_sat = 32'sh8000_0000;
		else
			pos_sat = prod_q[31:0];
	end

	// operand select for the shared unit
	always_comb begin
		it_start   = 1'b0;
		it_mode    = MODE_DIV;
		it_operand = '0;
		it_divisor = '0;
		it_steps   = '0;
		case (state_q)
			S_SQ: begin
				it_start   = 1'b1;
				it_mode    = MODE_SQRT;
				it_operand = {sq, 4'b0000, 6'd0};
				it_steps   = 6'd18;
			end
			S_SQRT: begin
				it_start   = it_done;
				it_operand = {dm_q, 10'd0};
				it_divisor = it_result[17:0];
				it_steps   = 6'd42;
			end
			S_DIV1: begin
				it_start   = it_done;
				it_operand = {h_q, 16'd0, 15'd0};
				it_divisor = {6'd0, lh_q};
				it_steps   = 6'd27;
			end
			default: begin
			end
		endcase
	end

	wtcm_iter_unit u_iter (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (it_start),
		.mode    (it_mode),
		.operand (it_operand),
		.divisor (it_divisor),
		.steps   (it_steps),
		.done    (it_done),
		.result  (it_result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			case (state_q)
				S_IDLE: if (accept && in_data.req_type == REQ_SETUP) state_q <= S_SQ;
				S_SQ:   state_q <= S_SQRT;
				S_SQRT: if (it_done) state_q <= S_DIV1;
				S_DIV1: if (it_done) state_q <= S_DIV2;
				S_DIV2: if (it_done) state_q <= S_POS;
				S_POS:  state_q <= S_LOAD;
				S_LOAD: state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && accept && in_data.req_type == REQ_SETUP) begin
			face_q   <= face_in;
			w_q      <= eff_size(cfg_q[{face_in, 1'b0}]);
			h_q      <= eff_size(cfg_q[{face_in, 1'b1}]);
			lh_q     <= (in_data.wall_line_height == 12'd0) ? 12'd1
			                                                 : in_data.wall_line_height;
			mx_q     <= in_data.dir_x[15] ? 16'(~in_data.dir_x + 16'd1) : in_data.dir_x;
			my_q     <= in_data.dir_y[15] ? 16'(~in_data.dir_y + 16'd1) : in_data.dir_y;
			mag_q    <= d_sel_neg ? 16'(~d_sel + 16'd1) : d_sel;
			dneg_q   <= d_sel_neg;
			dist_q   <= in_data.hit_distance;
			pos_q    <= in_data.hit_side ? in_data.player_x : in_data.player_y;
			mirror_q <= in_data.hit_side ? (!in_data.dir_y[15] && in_data.dir_y != 16'd0)
			                             : in_data.dir_x[15];
			s0_q     <= in_data.span_start;
			s1_q     <= in_data.span_end;
			col_q    <= in_data.screen_column;
		end
		if (state_q == S_SQ)
			dm_q <= 32'(dist_q * mag_q);
		if (state_q == S_SQRT && it_done)
			len_zero_q <= it_result[17:0] == 18'd0;
		if (state_q == S_DIV1 && it_done)
			uprod_q <= 27'(frac * w_q);
		if (state_q == S_DIV2 && it_done)
			step_q <= it_result[26:0];
		if (state_q == S_POS)
			prod_q <= 42'(m * $signed({1'b0, step_q}));
	end

	assign pix_load          = state_q == S_LOAD;
	assign load_data.active  = s0_q <= s1_q;
	assign load_data.row     = s0_q;
	assign load_data.end_row = s1_q;
	assign load_data.column  = col_q;
	assign load_data.face    = face_q;
	assign load_data.u       = u_fin[9:0];
	assign load_data.pos     = pos_sat;
	assign load_data.step    = {5'd0, step_q};

	wtcm_pixel_gen u_pix (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (pix_load),
		.load_data (load_data),
		.tick      (accept && in_data.req_type == REQ_TICK),
		.heights   (heights),
		.out_stall (out_stall),
		.out_valid (out_valid),
		.out_data  (out_data)
	);

`ifndef SYNTHESIS
	a_busy_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> in_stall)
		else $error("input taken during setup");
	a_setup_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && in_data.req_type == REQ_SETUP) |=> state_q == S_SQ)
		else $error("setup beat did not start the sequencer");
	a_done_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		it_done |-> (state_q == S_SQRT || state_q == S_DIV1 || state_q == S_DIV2))
		else $error("shared unit finished outside a wait state");
	a_load_idle: assert property (@(posedge clk) disable iff (!arst_n)
		pix_load |=> state_q == S_IDLE)
		else $error("sequencer did not return to idle after load");
`endif

endmodule

/* test/tb_wall_texture_column_mapper_unit.sv */
// ----------------------------------------------------------------------------
// tb_wall_texture_column_mapper_unit
// Self-checking bench for the wall texture column mapper.
// ----------------------------------------------------------------------------
// A scoreboard predicts the texel beat of each accepted tick from its own copy
// of the size registers and the column state. Stimulus runs directed corner
// columns, then random columns of ticks mixed with noise, under random stalls.
// ----------------------------------------------------------------------------
module tb_wall_texture_column_mapper_unit;
	import wtcm_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT = 1500000;

	class texel_scoreboard;
		logic [10:0] size_reg [8];
		bit          col_on;
		logic [10:0] row_now, row_last;
		logic [11:0] col_hold;
		logic [1:0]  face_hold;
		logic [9:0]  u_hold;
		logic [31:0] tpos, tstep;
		out_item_t   pending [$];
		int          mismatches;

		function new();
			foreach (size_reg[i]) size_reg[i] = 11'd64;
			col_on = 0;
			mismatches = 0;
		endfunction

		function automatic longint clip_size(logic [10:0] v);
			if (v == 0) return 1;
			if (v > 1024) return 1024;
			return v;
		endfunction

		function automatic longint int_sqrt(longint unsigned n);
			longint unsigned res, b;
			res = 0;
			b = 64'd1 << 62;
			while (b > n) b >>= 2;
			while (b != 0) begin
				if (n >= res + b) begin
					n -= res + b;
					res = (res >> 1) + b;
				end else begin
					res >>= 1;
				end
				b >>= 2;
			end
			return res;
		endfunction

		function void write_reg(logic [2:0] idx, logic [10:0] val);
			size_reg[idx] = val;
		endfunction

		function void note_input(in_item_t it);
			longint dx, dy, d, pos, hit, mg, off, len, w, h, lh, m, prod, p, v;
			longint unsigned u;
			logic [1:0] fc;
			if (it.req_type == REQ_SETUP) begin
				if (it.hit_side == 0) fc = it.step_negative ? FACE_EAST : FACE_WEST;
				else fc = it.step_negative ? FACE_SOUTH : FACE_NORTH;
				w = clip_size(size_reg[fc * 2]);
				h = clip_size(size_reg[fc * 2 + 1]);
				dx = it.dir_x;
				dy = it.dir_y;
				len = int_sqrt((dx * dx + dy * dy) << 4);
				d = it.hit_side == 0 ? dy : dx;
				pos = it.hit_side == 0 ? longint'(it.player_y) : longint'(it.player_x);
				mg = d < 0 ? -d : d;
				off = len != 0 ? (longint'(it.hit_distance) * mg * 1024) / len : 0;
				hit = pos * 256 + (d < 0 ? -off : off);
				u = ((hit & 64'hFFFF) * w) >> 16;
				if ((it.hit_side == 0 && dx < 0) || (it.hit_side == 1 && dy > 0))
					u = w - 1 - u;
				lh = it.wall_line_height == 0 ? 1 : it.wall_line_height;
				tstep = 32'((h << 16) / lh);
				m = longint'(it.span_start) - VIEW_ROWS / 2 + lh / 2;
				prod = m * longint'(tstep);
				if (prod > 64'sd2147483647) prod = 64'sd2147483647;
				if (prod < -64'sd2147483648) prod = -64'sd2147483648;
				tpos = 32'(prod);
				face_hold = fc;
				u_hold = 10'(u);
				col_hold = it.screen_column;
				row_now = it.span_start;
				row_last = it.span_end;
				col_on = it.span_start <= it.span_end;
			end else if (col_on) begin
				out_item_t r;
				h = clip_size(size_reg[face_hold * 2 + 1]);
				p = longint'($signed(tpos));
				if (p < 0) v = 0;
				else begin
					v = p >>> 16;
					if (v >= h) v = h - 1;
				end
				p += longint'(tstep);
				if (p > 64'sd2147483647) p = 64'sd2147483647;
				tpos = 32'(p);
				r.pixel_column = col_hold;
				r.pixel_row = row_now;
				r.face = face_hold;
				r.texel_u = u_hold;
				r.texel_v = 10'(v);
				r.last_pixel = row_now == row_last;
				pending.push_back(r);
				if (r.last_pixel) col_on = 0;
				else row_now = 11'(row_now + 1);
			end
		endfunction

		function void check_result(out_item_t got);
			out_item_t exp_r;
			if (pending.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected beat %p", got);
				return;
			end
			exp_r = pending.pop_front();
			if (got !== exp_r) begin
				mismatches++;
				if (mismatches <= 10) $display("mismatch exp %p got %p", exp_r, got);
			end
		endfunction
	endclass

	logic      clk, arst_n;
	logic      in_valid, in_stall, out_valid, out_stall, cfg_valid, cfg_ready;
	in_item_t  in_data;
	out_item_t out_data;
	logic [2:0]  cfg_index;
	logic [10:0] cfg_data;
	bit        quiet;
	longint    cycles;
	texel_scoreboard sb;

	wall_texture_column_mapper_unit u_top (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	initial begin
		clk = 0;
		forever #10 clk = ~clk;
	end

	initial begin
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > CYCLE_LIMIT) begin
				$display("TEST FAILED");
				$finish;
			end
		end
	end

	// output side: sample at rising edge, stall changes at falling edge
	initial begin
		int gap;
		out_stall = 0;
		forever begin
			@(posedge clk);
			if (arst_n && out_valid && !out_stall) sb.check_result(out_data);
			@(negedge clk);
			if (gap > 0) gap--;
			else if (!quiet && $urandom_range(0, 9) == 0) gap = $urandom_range(1, 18);
			out_stall = (gap > 0) && !quiet;
		end
	end

	// valid stays up after a beat so the next beat can follow without a gap
	task automatic send_item(in_item_t it);
		if (!quiet && $urandom_range(0, 7) == 0) begin
			in_valid <= 0;
			repeat ($urandom_range(1, 18)) @(negedge clk);
		end
		in_data <= it;
		in_valid <= 1;
		do @(posedge clk); while (in_stall);
		sb.note_input(it);
		@(negedge clk);
	endtask

	task automatic write_size(logic [2:0] idx, logic [10:0] val);
		cfg_index <= idx;
		cfg_data <= val;
		cfg_valid <= 1;
		do @(posedge clk); while (!cfg_ready);
		sb.write_reg(idx, val);
		@(negedge clk);
	endtask

	task automatic drain();
		in_valid <= 0;
		while (sb.pending.size() != 0) @(negedge clk);
		repeat (100) @(negedge clk);
	endtask

	function automatic in_item_t rand_setup(int rows);
		in_item_t it;
		logic [159:0] raw;
		raw = {$urandom, $urandom, $urandom, $urandom, $urandom};
		it = raw[$bits(in_item_t)-1:0];
		it.req_type = REQ_SETUP;
		it.span_start = 11'($urandom_range(0, 2047));
		if (it.span_start + rows > 2047) it.span_start = 11'(2047 - rows);
		it.span_end = 11'(it.span_start + rows);
		return it;
	endfunction

	task automatic tick();
		in_item_t it;
		logic [159:0] raw;
		raw = {$urandom, $urandom, $urandom, $urandom, $urandom};
		it = raw[$bits(in_item_t)-1:0];
		it.req_type = REQ_TICK;
		send_item(it);
	endtask

	task automatic column_run(in_item_t it, int nticks);
		send_item(it);
		repeat (nticks) tick();
	endtask

	initial begin
		in_item_t it;
		int n;
		sb = new();
		quiet = 0;
		arst_n = 0;
		in_valid = 0;
		in_data = '0;
		cfg_valid = 0;
		cfg_index = '0;
		cfg_data = '0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// directed: tick while idle, zero direction, extremes, empty span
		tick();
		it = '0;
		it.wall_line_height = 12'd0;
		it.span_end = 11'd3;
		column_run(it, 5);
		it = '1;
		it.req_type = REQ_SETUP;
		it.span_start = 11'd2045;
		column_run(it, 4);
		it.hit_side = 0; it.step_negative = 0;
		it.dir_x = 16'sh8000; it.dir_y = 16'sh7FFF;
		it.span_start = 0; it.span_end = 2;
		it.wall_line_height = 12'd1;
		column_run(it, 3);
		it.hit_side = 1; it.step_negative = 1;
		it.dir_x = 16'sh7FFF; it.dir_y = 16'sh0001;
		it.span_start = 5; it.span_end = 4;
		column_run(it, 2);
		// setup in the middle of a column
		column_run(rand_setup(6), 2);
		column_run(rand_setup(1), 3);
		drain();

		// size settings: min, max, over-range, random
		for (int ph = 0; ph < 5; ph++) begin
			for (int i = 0; i < 8; i++) begin
				case (ph)
					0: write_size(3'(i), 11'd0);
					1: write_size(3'(i), 11'd1024);
					2: write_size(3'(i), 11'd2047);
					default: write_size(3'(i), 11'($urandom_range(0, 2047)));
				endcase
			end
			cfg_valid <= 0;
			n = 0;
			while (n < 80) begin
				if (ph == 4 && n > 40) quiet = 1;
				case ($urandom_range(0, 9))
					0: begin tick(); n++; end
					1: begin send_item(rand_setup($urandom_range(0, 2047) % 7 - 1)); n++; end
					default: begin
						int r;
						r = $urandom_range(0, 8);
						column_run(rand_setup(r), r + 1 - $urandom_range(0, 1));
						n += r + 2;
					end
				endcase
			end
			drain();
		end

		if (sb.mismatches == 0 && sb.pending.size() == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end
endmodule

/* sim.f */
hdl/wtcm_pkg.sv
hdl/wtcm_iter_unit.sv
hdl/wtcm_pixel_gen.sv
hdl/wall_texture_column_mapper_unit.sv
test/tb_wall_texture_column_mapper_unit.sv
